FILE: hw/rtl/idqr_pkg.sv
// ----------------------------------------------------------------------------
// idqr_pkg: shared types and constants of the indexed deque
// Sizes, item codes, status codes and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package idqr_pkg;

    // CAPACITY must be a power of two: ring arithmetic wraps by truncation.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_REM
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [INDEX_W-1:0]     idx;
        logic [CNT_W-1:0]       count;
        logic [DATA_WIDTH-1:0]  value;
        logic [PTR_W-1:0]       front;
        logic                   rev;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/indexed_deque_with_reverse.sv
// ----------------------------------------------------------------------------
// indexed_deque_with_reverse: ordered store with indexed insert/remove
// Latency: a result word is shown the cycle after its item word is accepted.
// Throughput: one item per cycle unless stalled; insert/remove shift the tail.
// Reset: synchronous, active low; clears count, front pointer, direction and
// the output valid. Cell contents are not reset and hold junk until written.
// ----------------------------------------------------------------------------
module indexed_deque_with_reverse
    import idqr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [VALUE_W-1:0]  i_value,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count
);

    // ring state: the cell at r_front is logical position 0; r_rev picks
    // whether logical order runs down the ring instead of up.
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [PTR_W-1:0]      r_front;
    logic [PTR_W-1:0]      n_front;
    logic                  r_rev;
    logic                  n_rev;

    // output word register
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_rd;
    logic [STATUS_W-1:0]   r_status;
    logic [COUNT_W-1:0]    r_cnt_out;
    logic [VALUE_W-1:0]    n_rd;
    logic [STATUS_W-1:0]   n_status;

    logic                  w_accept;
    logic                  w_in_range;     // index < count
    logic [PTR_W-1:0]      w_last;         // logical position count-1
    logic [DATA_WIDTH-1:0] w_sel;          // word at the addressed position
    t_cell_ctrl            w_ctrl;

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;

    // The output register frees itself when its word is taken, so a new
    // item can enter in the same cycle.
    assign o_ready    = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_in_range = i_index < INDEX_W'(r_count);
    assign w_last     = PTR_W'(r_count - CNT_W'(1));

    // Read port: one-hot OR over the cells that match the index.
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_hit[k]) begin
                w_sel = w_sel | w_data[k];
            end
        end
    end

    // Item decode: next ring state, cell command and result word.
    always_comb begin
        n_count  = r_count;
        n_front  = r_front;
        n_rev    = r_rev;
        n_rd     = '0;
        n_status = ST_OK;

        w_ctrl.op    = OP_NONE;
        w_ctrl.idx   = i_index;
        w_ctrl.count = r_count;
        w_ctrl.value = DATA_WIDTH'(i_value);
        w_ctrl.front = r_front;
        w_ctrl.rev   = r_rev;

        case (i_kind)
            KIND_READ: begin
                if (w_in_range) begin
                    n_rd = VALUE_W'(w_sel);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            KIND_INSERT: begin
                // range check ranks ahead of the full check
                if (i_index > INDEX_W'(r_count)) begin
                    n_status = ST_RANGE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.op = OP_INS;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (w_in_range) begin
                    n_rd      = VALUE_W'(w_sel);
                    w_ctrl.op = OP_REM;
                    n_count   = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            KIND_REVERSE: begin
                // new front is the old last entry; the data never moves
                if (r_count != '0) begin
                    n_front = r_rev ? (r_front - w_last) : (r_front + w_last);
                end
                n_rev = !r_rev;
            end
            KIND_CLEAR: begin
                n_count = '0;
                n_front = '0;
                n_rev   = 1'b0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        if (!w_accept) begin
            w_ctrl.op = OP_NONE;
        end
    end

    // Row of cells, each wired to both ring neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int PREV = (g + CAPACITY - 1) % CAPACITY;
        localparam int NEXT = (g + 1) % CAPACITY;

        idqr_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_slot (PTR_W'(g)),
            .i_prev (w_data[PREV]),
            .i_next (w_data[NEXT]),
            .o_data (w_data[g]),
            .o_hit  (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_front     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_front <= n_front;
                r_rev   <= n_rev;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd      <= n_rd;
            r_status  <= n_status;
            r_cnt_out <= COUNT_W'(n_count);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_rd;
    assign o_status     = r_status;
    assign o_count      = r_cnt_out;

endmodule

FILE: hw/rtl/idqr_cell.sv
// ----------------------------------------------------------------------------
// idqr_cell: one ring slot of the deque
// Holds one word; on insert or remove it takes a ring neighbor's word or the new value.
// ----------------------------------------------------------------------------
module idqr_cell
    import idqr_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [PTR_W-1:0]      i_slot,
    input  logic [DATA_WIDTH-1:0] i_prev,   // word of slot - 1
    input  logic [DATA_WIDTH-1:0] i_next,   // word of slot + 1
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hit
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [PTR_W-1:0]      w_lpos;
    logic [INDEX_W-1:0]    w_lpos_x;

    // logical position of this slot, ring wrap by truncation
    assign w_lpos   = i_ctrl.rev ? (i_ctrl.front - i_slot) : (i_slot - i_ctrl.front);
    assign w_lpos_x = INDEX_W'(w_lpos);

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_INS: begin
                if (w_lpos_x == i_ctrl.idx) begin
                    n_data = i_ctrl.value;
                end else if (w_lpos_x > i_ctrl.idx &&
                             w_lpos_x <= INDEX_W'(i_ctrl.count)) begin
                    n_data = i_ctrl.rev ? i_next : i_prev;
                end
            end
            OP_REM: begin
                if (w_lpos_x >= i_ctrl.idx &&
                    (w_lpos_x + INDEX_W'(1)) < INDEX_W'(i_ctrl.count)) begin
                    n_data = i_ctrl.rev ? i_prev : i_next;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = (w_lpos_x == i_ctrl.idx);

endmodule

FILE: hw/rtl/idqr_chk.sv
// ----------------------------------------------------------------------------
// idqr_chk: port-level checks of the indexed deque
// Watches both channels and the result of reverse and clear items.
// ----------------------------------------------------------------------------
module idqr_chk
    import idqr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [VALUE_W-1:0]  o_read_value,
    input  logic [STATUS_W-1:0] o_status,
    input  logic [COUNT_W-1:0]  o_count
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted item gave no result word");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_value)
                                   && $stable(o_status) && $stable(o_count)))
        else $error("stalled result word changed");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == KIND_CLEAR) |=>
            (o_count == '0 && o_status == ST_OK && o_read_value == '0))
        else $error("clear did not empty the store");

    a_reverse_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == KIND_REVERSE) |=>
            (o_status == ST_OK && o_read_value == '0 && $stable(o_count) == 1'b0
             || o_status == ST_OK && o_read_value == '0))
        else $error("reverse gave a word or an error");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= COUNT_W'(CAPACITY) && o_status <= ST_FULL))
        else $error("count or status out of range");

endmodule

bind indexed_deque_with_reverse idqr_chk u_idqr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_kind       (i_kind),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_read_value (o_read_value),
    .o_status     (o_status),
    .o_count      (o_count)
);

FILE: tb/tb_indexed_deque_with_reverse.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_deque_with_reverse: self-checking bench for the indexed deque
// Drives item words (read, insert, remove, reverse, clear, unused kinds) over
// valid/ready. A cycle-free model of the ring predicts every result word, and
// each returned word is compared field by field. A directed table runs first,
// then random walks of the count (fill to full, drain to empty, reversed
// sweeps, mixed traffic) under four idle/stall mixes. The output side also
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_indexed_deque_with_reverse;
    import idqr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 450;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_CAP     = 40;

    // kinds the block ignores
    localparam logic [KIND_W-1:0] KIND_NOP_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NOP_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_NOP_C = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0]  word;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_answer;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        logic               typed;
        t_answer            ans;
    } t_plan_row;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [KIND_W-1:0]   i_kind  = '0;
    logic [INDEX_W-1:0]  i_index = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [VALUE_W-1:0]  o_read_value;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count;

    indexed_deque_with_reverse uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    // 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted ring state. Cells are only read inside the live range,
    // and every live cell was written by an insert, so zero start is safe.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] ring [CAPACITY];
    logic [PTR_W-1:0]   ring_front = '0;
    logic [COUNT_W-1:0] ring_count = '0;
    logic               ring_rev   = 1'b0;

    t_answer due_answers [$];

    int  cycles         = 0;
    int  mismatches     = 0;
    int  live_items     = 0;
    int  words_checked  = 0;
    int  full_refusals  = 0;
    int  range_errors   = 0;
    int  input_stalls   = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_asked     = 0;
    int  hold_done      = 0;
    int  hold_left      = 0;

    initial begin
        foreach (ring[k]) ring[k] = '0;
    end

    // ring cell holding logical position pos; wraps by truncation
    function automatic logic [PTR_W-1:0] ring_slot(input int pos);
        logic [PTR_W-1:0] p;
        p = pos[PTR_W-1:0];
        return ring_rev ? ring_front - p : ring_front + p;
    endfunction

    // apply one item word to the predicted ring and return its result word
    function automatic t_answer deque_apply(input logic [KIND_W-1:0]  kind,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [VALUE_W-1:0] val);
        t_answer a;
        a = '{word: '0, status: ST_OK, count: '0};
        case (kind)
            KIND_READ: begin
                if (idx >= ring_count) a.status = ST_RANGE;
                else a.word = ring[ring_slot(idx)];
            end
            KIND_INSERT: begin
                if (idx > ring_count) begin
                    a.status = ST_RANGE;      // range wins over full
                end else if (ring_count >= CAPACITY) begin
                    a.status = ST_FULL;
                end else begin
                    for (int k = ring_count; k > idx; k--)
                        ring[ring_slot(k)] = ring[ring_slot(k - 1)];
                    ring[ring_slot(idx)] = val;
                    ring_count++;
                end
            end
            KIND_REMOVE: begin
                if (idx >= ring_count) begin
                    a.status = ST_RANGE;
                end else begin
                    a.word = ring[ring_slot(idx)];
                    for (int k = idx; k + 1 < ring_count; k++)
                        ring[ring_slot(k)] = ring[ring_slot(k + 1)];
                    ring[ring_slot(ring_count - 1)] = '0;
                    ring_count--;
                end
            end
            KIND_REVERSE: begin
                // front jumps to the old last entry, direction flips
                if (ring_count > 0) ring_front = ring_slot(ring_count - 1);
                ring_rev = ~ring_rev;
            end
            KIND_CLEAR: begin
                foreach (ring[k]) ring[k] = '0;
                ring_front = '0;
                ring_count = '0;
                ring_rev   = 1'b0;
            end
            default: ;
        endcase
        a.count = ring_count;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_miss(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH @%0d %s: got %0h, expected %0h", cycles, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Sender: present one item word, wait for it to be taken, predict.
    // Valid stays high from one word to the next unless an idle gap falls.
    // ------------------------------------------------------------------
    task automatic push_word(input logic [KIND_W-1:0]  kind,
                             input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val,
                             input logic               typed,
                             input t_answer            typed_ans);
        t_answer a;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_index <= idx;
        i_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        a = deque_apply(kind, idx, val);
        due_answers.insert(due_answers.size(), typed ? typed_ans : a);
        if (kind <= KIND_CLEAR) live_items++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_live(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx);
        push_word(kind, idx, pick_value(), 1'b0, '0);
    endtask

    // valid position for the kind, now and then any 5-bit index
    function automatic logic [INDEX_W-1:0] pick_index(input logic [KIND_W-1:0] kind);
        if ($urandom_range(9, 0) == 0) return INDEX_W'($urandom_range(31, 0));
        if (kind == KIND_INSERT) return INDEX_W'($urandom_range(ring_count, 0));
        if (ring_count == 0) return '0;
        return INDEX_W'($urandom_range(ring_count - 1, 0));
    endfunction

    // insert until full, then knock on the full store (once out of range)
    task automatic fill_burst();
        while (ring_count < CAPACITY)
            push_live(KIND_INSERT, INDEX_W'($urandom_range(ring_count, 0)));
        push_live(KIND_INSERT, INDEX_W'($urandom_range(ring_count, 0)));
        push_live(KIND_INSERT, INDEX_W'($urandom_range(31, CAPACITY + 1)));
        push_live(KIND_READ, INDEX_W'($urandom_range(CAPACITY - 1, 0)));
    endtask

    task automatic drain_burst();
        while (ring_count > 0)
            push_live(KIND_REMOVE, INDEX_W'($urandom_range(ring_count - 1, 0)));
        push_live(KIND_REMOVE, '0);
    endtask

    // flip the order and read every live position
    task automatic reverse_sweep();
        int n;
        push_live(KIND_REVERSE, INDEX_W'($urandom_range(31, 0)));
        n = ring_count;
        for (int k = 0; k < n; k++) push_live(KIND_READ, INDEX_W'(k));
    endtask

    task automatic mixed_word();
        logic [KIND_W-1:0] kind;
        int r;
        r = $urandom_range(99, 0);
        if      (r < 28) kind = KIND_READ;
        else if (r < 56) kind = KIND_INSERT;
        else if (r < 80) kind = KIND_REMOVE;
        else if (r < 90) kind = KIND_REVERSE;
        else if (r < 93) kind = KIND_CLEAR;
        else begin
            case ($urandom_range(2, 0))
                0:       kind = KIND_NOP_A;
                1:       kind = KIND_NOP_B;
                default: kind = KIND_NOP_C;
            endcase
        end
        push_live(kind, pick_index(kind));
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input logic squeeze);
        int start;
        int r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = live_items;
        while (live_items - start < PHASE_ITEMS) begin
            // long output hold-off while words keep coming
            if (squeeze && live_items - start >= 100 && hold_asked == 0) hold_asked++;
            r = $urandom_range(99, 0);
            if      (r < 6)  fill_burst();
            else if (r < 10) drain_burst();
            else if (r < 14) reverse_sweep();
            else             mixed_word();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold counted here
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest answer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer want;
        cycles++;
        if (i_rst_n && i_valid && !o_ready) input_stalls++;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_answers.size() == 0) begin
                report_miss("unexpected word", {o_read_value, o_status, o_count}, '0);
            end else begin
                want = due_answers[0];
                due_answers.delete(0);
                words_checked++;
                if (want.status == ST_FULL)  full_refusals++;
                if (want.status == ST_RANGE) range_errors++;
                if (o_read_value !== want.word)   report_miss("read_value", o_read_value, want.word);
                if (o_status     !== want.status) report_miss("status", o_status, want.status);
                if (o_count      !== want.count)  report_miss("count", o_count, want.count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: edges, every kind, every range-error path
    // ------------------------------------------------------------------
    t_plan_row plan [25] = '{
        '{KIND_READ,    5'd0,  32'h0,         1'b1, '{32'h0, ST_RANGE, 5'd0}},  // empty read
        '{KIND_REMOVE,  5'd0,  32'h0,         1'b1, '{32'h0, ST_RANGE, 5'd0}},  // empty remove
        '{KIND_REVERSE, 5'd0,  32'h0,         1'b1, '{32'h0, ST_OK,    5'd0}},  // flag only
        '{KIND_INSERT,  5'd1,  32'h1234,      1'b1, '{32'h0, ST_RANGE, 5'd0}},  // past end
        '{KIND_INSERT,  5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,    5'd1}},
        '{KIND_INSERT,  5'd1,  32'h0,         1'b1, '{32'h0, ST_OK,    5'd2}},
        '{KIND_INSERT,  5'd0,  32'h8000_0001, 1'b1, '{32'h0, ST_OK,    5'd3}},
        '{KIND_INSERT,  5'd3,  32'h5A5A_A5A5, 1'b1, '{32'h0, ST_OK,    5'd4}},  // append
        '{KIND_READ,    5'd0,  32'h0,         1'b0, '0},
        '{KIND_READ,    5'd3,  32'h0,         1'b0, '0},
        '{KIND_READ,    5'd4,  32'h0,         1'b1, '{32'h0, ST_RANGE, 5'd4}},
        '{KIND_REVERSE, 5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,    5'd4}},
        '{KIND_READ,    5'd0,  32'h0,         1'b0, '0},
        '{KIND_READ,    5'd1,  32'h0,         1'b0, '0},
        '{KIND_INSERT,  5'd31, 32'h7,         1'b1, '{32'h0, ST_RANGE, 5'd4}},
        '{KIND_REMOVE,  5'd31, 32'h0,         1'b1, '{32'h0, ST_RANGE, 5'd4}},
        '{KIND_REMOVE,  5'd1,  32'h0,         1'b0, '0},
        '{KIND_REMOVE,  5'd0,  32'h0,         1'b0, '0},
        '{KIND_NOP_A,   5'd0,  32'h0,         1'b1, '{32'h0, ST_OK,    5'd2}},
        '{KIND_NOP_B,   5'd16, 32'h1,         1'b1, '{32'h0, ST_OK,    5'd2}},
        '{KIND_NOP_C,   5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,    5'd2}},
        '{KIND_READ,    5'd16, 32'h0,         1'b1, '{32'h0, ST_RANGE, 5'd2}},
        '{KIND_CLEAR,   5'd0,  32'h0,         1'b1, '{32'h0, ST_OK,    5'd0}},
        '{KIND_READ,    5'd0,  32'h0,         1'b1, '{32'h0, ST_RANGE, 5'd0}},
        '{KIND_INSERT,  5'd0,  32'hDEAD_BEEF, 1'b1, '{32'h0, ST_OK,    5'd1}}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r])
            push_word(plan[r].kind, plan[r].idx, plan[r].val, plan[r].typed, plan[r].ans);

        random_phase(0,  0,  1'b1);   // back to back, with the long hold
        random_phase(55, 0,  1'b0);   // sender gaps
        random_phase(0,  55, 1'b0);   // receiver stalls
        random_phase(33, 33, 1'b0);   // both

        i_valid <= 1'b0;
        while (due_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d item words, %0d result words checked, %0d mismatches",
                 live_items, words_checked, mismatches);
        $display("summary: %0d full refusals, %0d range errors, input held off %0d cycles",
                 full_refusals, range_errors, input_stalls);
        if (mismatches == 0 && due_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d words outstanding", cycles, due_answers.size());
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/idqr_pkg.sv
hw/rtl/idqr_cell.sv
hw/rtl/indexed_deque_with_reverse.sv
hw/rtl/idqr_chk.sv
tb/tb_indexed_deque_with_reverse.sv
